// ===== src/sfs_pkg.sv =====
`timescale 1ns / 1ps

package sfs_pkg;

    localparam int SEG_LEN   = 512;
    localparam int LIMB_SEGS = 9;

    localparam int CNT_W  = $clog2(SEG_LEN + 1);
    localparam int SEG_W  = $clog2(LIMB_SEGS + 1);
    localparam int EL_W   = 16;
    localparam int PROD_W = 2 * EL_W;
    localparam int ACC_W  = 40;
    localparam int LSUM_W = 20;
    localparam int NUM_W  = 22;
    localparam int QUO_W  = NUM_W - 1;
    localparam int DEN_W  = 6;
    localparam int DIVC_W = $clog2(QUO_W);
    localparam int SIM_W  = 15;
    localparam int LCNT_W = 4;

    localparam logic signed [EL_W-1:0] VIS_LIMIT = -16'sd3276;
    localparam logic signed [EL_W-1:0] THR_RESET = 16'sd16384;

    typedef enum logic [2:0] {
        ST_RUN,
        ST_DRAIN,
        ST_PREP,
        ST_DIV,
        ST_OUT
    } sfs_state_t;

    typedef struct packed {
        logic accept;
        logic prep;
        logic div_step;
        logic load_out;
    } sfs_cmd_t;

    typedef struct packed {
        logic last_accept;
        logic pipe_busy;
        logic div_last;
        logic out_free;
    } sfs_status_t;

endpackage

// ===== src/sfs_ctrl.sv =====
`timescale 1ns / 1ps

module sfs_ctrl
    import sfs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  sfs_status_t status,
    output sfs_cmd_t    cmd
);

    sfs_state_t state_reg;
    sfs_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_RUN:
            begin
                if (status.last_accept)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (status.div_last)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    state_next = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_RUN:   cmd.accept   = 1'b1;
            ST_DRAIN: cmd          = '0;
            ST_PREP:  cmd.prep     = 1'b1;
            ST_DIV:   cmd.div_step = 1'b1;
            ST_OUT:   cmd.load_out = status.out_free;
            default:  cmd          = '0;
        endcase
    end

endmodule

// ===== src/sfs_datapath.sv =====
`timescale 1ns / 1ps

module sfs_datapath
    import sfs_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  sfs_cmd_t                cmd,
    output sfs_status_t             status,
    input  logic                    cfg_valid,
    input  logic signed [EL_W-1:0]  cfg_data,
    input  logic                    in_valid,
    input  logic signed [EL_W-1:0]  src_element,
    input  logic signed [EL_W-1:0]  dst_element,
    input  logic                    last,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [SIM_W-1:0]        similarity,
    output logic [LCNT_W-1:0]       limbs_counted,
    output logic                    torso_seen
);

    logic signed [EL_W-1:0]   thr_reg;

    logic [CNT_W-1:0]         cnt_reg;
    logic [SEG_W-1:0]         seg_idx_reg;
    logic                     seg_vis_reg;

    logic                     s1_valid_reg, s1_mac_reg, s1_first_reg, s1_close_reg;
    logic                     s1_torso_reg, s1_vis_reg;
    logic signed [PROD_W-1:0] prod_reg;

    logic                     s2_valid_reg, s2_torso_reg, s2_vis_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    logic                     s3_valid_reg, s3_torso_reg, s3_vis_reg;
    logic signed [EL_W-1:0]   dot_reg;

    logic [LCNT_W-1:0]        limb_count_reg;
    logic signed [LSUM_W-1:0] limb_sum_reg;
    logic signed [EL_W-1:0]   torso_dot_reg;
    logic                     torso_vis_reg;

    logic [DEN_W-1:0]         rem_reg;
    logic [DEN_W-1:0]         den_reg;
    logic [QUO_W-1:0]         numq_reg;
    logic [DIVC_W-1:0]        div_cnt_reg;
    logic [LCNT_W-1:0]        res_limbs_reg;
    logic                     res_torso_reg;

    logic                     out_valid_reg;
    logic [SIM_W-1:0]         sim_reg;
    logic [LCNT_W-1:0]        out_limbs_reg;
    logic                     out_torso_reg;

    // element intake
    logic                     fire;
    logic                     first;
    logic                     in_range;
    logic [CNT_W-1:0]         cnt_inc;
    logic                     is_torso;
    logic                     close;
    logic                     vis_in;
    logic                     vis_now;

    assign fire     = in_valid && cmd.accept;
    assign first    = (cnt_reg == '0);
    assign in_range = (cnt_reg < CNT_W'(SEG_LEN));
    assign cnt_inc  = in_range ? cnt_reg + 1'b1 : cnt_reg;
    assign is_torso = (seg_idx_reg >= SEG_W'(LIMB_SEGS));
    assign close    = last || (!is_torso && (cnt_inc == CNT_W'(SEG_LEN)));
    assign vis_in   = !((src_element < VIS_LIMIT) || (dst_element < VIS_LIMIT));
    assign vis_now  = first ? vis_in : seg_vis_reg;

    // saturating accumulate
    logic signed [ACC_W:0]   acc_base;
    logic signed [ACC_W:0]   acc_sum;
    logic signed [ACC_W-1:0] acc_sat;

    assign acc_base = s1_first_reg ? '0 : {acc_reg[ACC_W-1], acc_reg};
    assign acc_sum  = acc_base + {{(ACC_W + 1 - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    always_comb
    begin
        if (acc_sum[ACC_W] != acc_sum[ACC_W-1])
        begin
            acc_sat = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                     : {1'b0, {(ACC_W-1){1'b1}}};
        end
        else
        begin
            acc_sat = acc_sum[ACC_W-1:0];
        end
    end

    // floor by 15 bits and saturate to q1.15
    logic                   dot_ovf;
    logic signed [EL_W-1:0] dot_next;

    assign dot_ovf = !((&acc_reg[ACC_W-1:EL_W+14]) || !(|acc_reg[ACC_W-1:EL_W+14]));

    always_comb
    begin
        if (dot_ovf)
        begin
            dot_next = acc_reg[ACC_W-1] ? {1'b1, {(EL_W-1){1'b0}}}
                                        : {1'b0, {(EL_W-1){1'b1}}};
        end
        else
        begin
            dot_next = acc_reg[EL_W+14:15];
        end
    end

    // score numerator and denominator
    logic                    limbs_ok;
    logic signed [NUM_W-1:0] torso_prod;
    logic signed [NUM_W-1:0] num_both;
    logic signed [NUM_W-1:0] num_sel;
    logic [DEN_W-1:0]        den_sel;
    logic                    num_pos;

    assign limbs_ok   = (limb_count_reg >= LCNT_W'(3));
    assign torso_prod = torso_dot_reg * $signed({1'b0, limb_count_reg});
    assign num_both   = {torso_prod[NUM_W-2:0], 1'b0} + NUM_W'(limb_sum_reg);

    always_comb
    begin
        if (limbs_ok && torso_vis_reg)
        begin
            num_sel = num_both;
            den_sel = DEN_W'({limb_count_reg, 1'b0}) + DEN_W'(limb_count_reg);
        end
        else if (limbs_ok)
        begin
            num_sel = NUM_W'(limb_sum_reg);
            den_sel = DEN_W'(limb_count_reg);
        end
        else if (torso_vis_reg)
        begin
            num_sel = NUM_W'(torso_dot_reg);
            den_sel = DEN_W'(1);
        end
        else
        begin
            num_sel = '0;
            den_sel = '0;
        end
    end

    assign num_pos = (den_sel != '0) && !num_sel[NUM_W-1] && (num_sel != '0);

    // restoring divide, one quotient bit per cycle
    logic [DEN_W:0] div_trial;
    logic [DEN_W:0] div_diff;
    logic           div_ge;

    assign div_trial = {rem_reg, numq_reg[QUO_W-1]};
    assign div_diff  = div_trial - {1'b0, den_reg};
    assign div_ge    = (div_trial >= {1'b0, den_reg});

    logic out_free;
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg        <= THR_RESET;
            cnt_reg        <= '0;
            seg_idx_reg    <= '0;
            seg_vis_reg    <= 1'b1;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            acc_reg        <= '0;
            limb_count_reg <= '0;
            limb_sum_reg   <= '0;
            torso_dot_reg  <= '0;
            torso_vis_reg  <= 1'b0;
            div_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                thr_reg <= cfg_data;
            end

            s1_valid_reg <= fire;
            if (fire)
            begin
                if (close)
                begin
                    cnt_reg     <= '0;
                    seg_vis_reg <= 1'b1;
                    if (!is_torso)
                    begin
                        seg_idx_reg <= seg_idx_reg + 1'b1;
                    end
                end
                else
                begin
                    cnt_reg     <= cnt_inc;
                    seg_vis_reg <= vis_now;
                end
            end

            s2_valid_reg <= s1_valid_reg && s1_close_reg;
            if (s1_valid_reg)
            begin
                if (s1_mac_reg)
                begin
                    acc_reg <= acc_sat;
                end
                else if (s1_first_reg)
                begin
                    acc_reg <= '0;
                end
            end

            s3_valid_reg <= s2_valid_reg;

            if (s3_valid_reg)
            begin
                if (!s3_torso_reg)
                begin
                    if (s3_vis_reg && (dot_reg > thr_reg))
                    begin
                        limb_count_reg <= limb_count_reg + 1'b1;
                        limb_sum_reg   <= limb_sum_reg + LSUM_W'(dot_reg);
                    end
                end
                else if (s3_vis_reg)
                begin
                    torso_dot_reg <= dot_reg;
                    torso_vis_reg <= 1'b1;
                end
            end

            if (cmd.prep)
            begin
                limb_count_reg <= '0;
                limb_sum_reg   <= '0;
                torso_dot_reg  <= '0;
                torso_vis_reg  <= 1'b0;
                seg_idx_reg    <= '0;
                cnt_reg        <= '0;
                seg_vis_reg    <= 1'b1;
                div_cnt_reg    <= '0;
            end
            else if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end

            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            prod_reg     <= src_element * dst_element;
            s1_mac_reg   <= in_range && vis_now;
            s1_first_reg <= first;
            s1_close_reg <= close;
            s1_torso_reg <= is_torso;
            s1_vis_reg   <= vis_now;
        end

        s2_torso_reg <= s1_torso_reg;
        s2_vis_reg   <= s1_vis_reg;

        if (s2_valid_reg)
        begin
            dot_reg      <= dot_next;
            s3_torso_reg <= s2_torso_reg;
            s3_vis_reg   <= s2_vis_reg;
        end

        if (cmd.prep)
        begin
            rem_reg       <= '0;
            numq_reg      <= num_pos ? num_sel[QUO_W-1:0] : '0;
            den_reg       <= num_pos ? den_sel : DEN_W'(1);
            res_limbs_reg <= limb_count_reg;
            res_torso_reg <= torso_vis_reg;
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= div_ge ? div_diff[DEN_W-1:0] : div_trial[DEN_W-1:0];
            numq_reg <= {numq_reg[QUO_W-2:0], div_ge};
        end

        if (cmd.load_out)
        begin
            sim_reg       <= (|numq_reg[QUO_W-1:SIM_W]) ? {SIM_W{1'b1}} : numq_reg[SIM_W-1:0];
            out_limbs_reg <= res_limbs_reg;
            out_torso_reg <= res_torso_reg;
        end
    end

    assign status.last_accept = fire && last;
    assign status.pipe_busy   = s1_valid_reg || s2_valid_reg || s3_valid_reg;
    assign status.div_last    = (div_cnt_reg == DIVC_W'(QUO_W - 1));
    assign status.out_free    = out_free;

    assign out_valid     = out_valid_reg;
    assign similarity    = sim_reg;
    assign limbs_counted = out_limbs_reg;
    assign torso_seen    = out_torso_reg;

endmodule

// ===== src/segmented_feature_similarity.sv =====
// segmented feature similarity of two feature templates
// input channel (in_valid / in_stall): one request per element pair, src_element and
//   dst_element in signed q1.15, segment-major: nine limb segments then the torso,
//   512 elements each; last marks the final torso element and closes the template pair
// elements are taken one per cycle while in_stall is low, through a registered multiply
//   and a 40-bit saturating accumulator
// after the request with last the input stalls while the pipeline drains, the score
//   fraction is formed, a bit-serial divider produces the quotient and the output
//   register is loaded once the output slot is free; then the next template pair
//   is taken
// output channel (out_valid / out_stall): one request per template pair with
//   similarity, limbs_counted and torso_seen; it is held while out_stall is high and
//   the next template pair streams in meanwhile; a new result waits for the slot
// configuration (cfg_valid / cfg_ready): cfg_data writes limb_threshold, always ready
// reset (rst_n low, asynchronous): pipeline and segment state cleared, no output
//   pending, limb_threshold back to 0.5
`timescale 1ns / 1ps

module segmented_feature_similarity
    import sfs_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic signed [EL_W-1:0]  cfg_data,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic signed [EL_W-1:0]  src_element,
    input  logic signed [EL_W-1:0]  dst_element,
    input  logic                    last,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [SIM_W-1:0]        similarity,
    output logic [LCNT_W-1:0]       limbs_counted,
    output logic                    torso_seen
);

    sfs_cmd_t    cmd;
    sfs_status_t status;

    assign cfg_ready = 1'b1;
    assign in_stall  = !cmd.accept;

    sfs_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    sfs_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_valid     (cfg_valid),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .src_element   (src_element),
        .dst_element   (dst_element),
        .last          (last),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .similarity    (similarity),
        .limbs_counted (limbs_counted),
        .torso_seen    (torso_seen)
    );

endmodule

// ===== dv/sfs_score_checker.sv =====
`timescale 1ns / 1ps

module sfs_score_checker
    import sfs_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic signed [EL_W-1:0]  cfg_data,
    input  logic                    in_valid,
    input  logic                    in_stall,
    input  logic signed [EL_W-1:0]  src_element,
    input  logic signed [EL_W-1:0]  dst_element,
    input  logic                    last,
    input  logic                    out_valid,
    input  logic                    out_stall,
    input  logic [SIM_W-1:0]        similarity,
    input  logic [LCNT_W-1:0]       limbs_counted,
    input  logic                    torso_seen,
    output int                      fail_count,
    output int                      pending,
    output int                      scores_seen
);

    localparam longint DOT_SUM_MAX = (64'sd1 <<< (ACC_W - 1)) - 1;
    localparam longint DOT_SUM_MIN = -(64'sd1 <<< (ACC_W - 1));
    localparam int     Q15_MAX     = 32767;
    localparam int     Q15_MIN     = -32768;

    typedef struct {
        logic [SIM_W-1:0]  sim;
        logic [LCNT_W-1:0] limbs;
        logic              torso;
    } score_t;

    score_t                  score_queue[$];
    logic signed [EL_W-1:0]  threshold;
    longint                  dot_sum;
    int                      seg_pos;
    bit                      seg_shown;
    int                      limbs_hit;
    int                      limb_dot_total;
    int                      torso_dot_q;
    int                      segs_closed;

    function automatic int dot_to_q15(longint acc);
        longint q;
        q = acc >>> 15;
        if (q > Q15_MAX)
            q = Q15_MAX;
        if (q < Q15_MIN)
            q = Q15_MIN;
        return int'(q);
    endfunction

    task automatic clear_template();
        dot_sum        = 0;
        seg_pos        = 0;
        seg_shown      = 1'b1;
        limbs_hit      = 0;
        limb_dot_total = 0;
        torso_dot_q    = 0;
        segs_closed    = 0;
    endtask

    task automatic take_pair(input int a, input int b, input bit closing);
        bit     in_torso;
        bit     torso_ok;
        int     dot;
        longint num;
        longint den;
        longint sim;
        score_t s;
        in_torso = segs_closed >= LIMB_SEGS;
        torso_ok = 1'b0;
        if (seg_pos == 0)
        begin
            seg_shown = !(a < int'(VIS_LIMIT) || b < int'(VIS_LIMIT));
            dot_sum   = 0;
        end
        // torso elements past the segment length are dropped
        if (seg_pos < SEG_LEN)
        begin
            if (seg_shown)
            begin
                dot_sum = dot_sum + longint'(a) * longint'(b);
                if (dot_sum > DOT_SUM_MAX)
                    dot_sum = DOT_SUM_MAX;
                if (dot_sum < DOT_SUM_MIN)
                    dot_sum = DOT_SUM_MIN;
            end
            seg_pos++;
        end
        if (closing || (!in_torso && seg_pos >= SEG_LEN))
        begin
            dot = dot_to_q15(dot_sum);
            if (!in_torso)
            begin
                if (seg_shown && dot > int'(threshold))
                begin
                    limbs_hit      = (limbs_hit + 1) & 15;
                    limb_dot_total = limb_dot_total + dot;
                end
                segs_closed++;
            end
            else if (seg_shown)
            begin
                torso_dot_q = dot;
                torso_ok    = 1'b1;
            end
            seg_pos   = 0;
            dot_sum   = 0;
            seg_shown = 1'b1;
        end
        if (closing)
        begin
            num = 0;
            den = 0;
            sim = 0;
            if (limbs_hit >= 3 && torso_ok)
            begin
                num = longint'(limb_dot_total) + 2 * longint'(torso_dot_q) * limbs_hit;
                den = 3 * limbs_hit;
            end
            else if (limbs_hit >= 3)
            begin
                num = limb_dot_total;
                den = limbs_hit;
            end
            else if (torso_ok)
            begin
                num = torso_dot_q;
                den = 1;
            end
            if (den > 0 && num > 0)
                sim = num / den;
            if (sim > Q15_MAX)
                sim = Q15_MAX;
            s.sim   = sim[SIM_W-1:0];
            s.limbs = limbs_hit[LCNT_W-1:0];
            s.torso = torso_ok;
            score_queue = {score_queue, s};
            clear_template();
        end
    endtask

    task automatic match_score();
        score_t want;
        if (score_queue.size() == 0)
        begin
            $error("unexpected score: similarity %0d, limbs_counted %0d, torso_seen %0d",
                   similarity, limbs_counted, torso_seen);
            fail_count++;
        end
        else
        begin
            want = score_queue.pop_front();
            if (similarity !== want.sim)
            begin
                $error("similarity: expected %0d, got %0d", want.sim, similarity);
                fail_count++;
            end
            if (limbs_counted !== want.limbs)
            begin
                $error("limbs_counted: expected %0d, got %0d", want.limbs, limbs_counted);
                fail_count++;
            end
            if (torso_seen !== want.torso)
            begin
                $error("torso_seen: expected %0d, got %0d", want.torso, torso_seen);
                fail_count++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold = THR_RESET;
            clear_template();
            score_queue.delete();
            fail_count  = 0;
            scores_seen = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                threshold = cfg_data;
            if (out_valid && !out_stall)
            begin
                match_score();
                scores_seen++;
            end
            if (in_valid && !in_stall)
                take_pair(src_element, dst_element, last);
        end
        pending = score_queue.size();
    end

endmodule

// ===== dv/tb_segmented_feature_similarity.sv =====
`timescale 1ns / 1ps

module tb_segmented_feature_similarity;
    import sfs_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 5;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 40;
    localparam int SHORT_BUDGET  = 30;
    localparam int PRESSURE_ITEMS = 70;

    typedef enum int {
        FILL_RANDOM,
        FILL_MATCHED,
        FILL_OPPOSED,
        FILL_NARROW,
        FILL_CORNER
    } fill_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic signed [EL_W-1:0]  cfg_data = '0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic signed [EL_W-1:0]  src_element = '0;
    logic signed [EL_W-1:0]  dst_element = '0;
    logic                    last = 1'b0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [SIM_W-1:0]        similarity;
    logic [LCNT_W-1:0]       limbs_counted;
    logic                    torso_seen;

    int      fail_count;
    int      pending;
    int      scores_seen;
    int      pairs_sent = 0;
    int      templates_sent = 0;
    int      settings_used = 0;
    longint  cycle_count = 0;
    bit      sender_idles = 1'b0;
    bit      receiver_idles = 1'b0;
    bit      hold_off = 1'b0;
    bit      hold_used = 1'b0;

    segmented_feature_similarity DUT (.*);

    sfs_score_checker checker_i (.*);

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL segmented_feature_similarity");
            $finish;
        end
    end

    // output side: random stalls while receiver_idles is set, plus one long hold-off on request
    initial
    begin
        @(posedge clk);
        forever
        begin
            if (hold_off && !hold_used)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_used = 1'b1;
            end
            else if (receiver_idles && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    task automatic send_pair(input logic signed [EL_W-1:0] s, input logic signed [EL_W-1:0] d,
                             input logic closing);
        if (sender_idles && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        src_element <= s;
        dst_element <= d;
        last        <= closing;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pairs_sent++;
        if (closing)
            templates_sent++;
    endtask

    function automatic logic [2*EL_W-1:0] make_pair(input fill_t fill, input bit lead,
                                                    input bit hide);
        int s;
        int d;
        int low;
        int corners[4] = '{-32768, -1, 0, 32767};
        case (fill)
            FILL_MATCHED:
            begin
                s = $urandom_range(0, 65535) - 32768;
                d = s;
            end
            FILL_OPPOSED:
            begin
                s = $urandom_range(0, 65535) - 32768;
                d = -s;
            end
            FILL_NARROW:
            begin
                s = $urandom_range(0, 4095) - 2048;
                d = $urandom_range(0, 4095) - 2048;
            end
            FILL_CORNER:
            begin
                s = corners[$urandom_range(0, 3)];
                d = corners[$urandom_range(0, 3)];
            end
            default:
            begin
                s = $urandom_range(0, 65535) - 32768;
                d = $urandom_range(0, 65535) - 32768;
            end
        endcase
        // first element of a segment decides its visibility
        if (lead)
        begin
            low = -$urandom_range(3277, 32768);
            if (hide)
            begin
                case ($urandom_range(0, 2))
                    0: s = low;
                    1: d = low;
                    default:
                    begin
                        s = low;
                        d = -$urandom_range(3277, 32768);
                    end
                endcase
            end
            else
            begin
                if (s < int'(VIS_LIMIT))
                    s = int'(VIS_LIMIT) + $urandom_range(0, 3276);
                if (d < int'(VIS_LIMIT))
                    d = int'(VIS_LIMIT) + $urandom_range(0, 3276);
            end
        end
        return {s[EL_W-1:0], d[EL_W-1:0]};
    endfunction

    task automatic send_template(input int end_seg, input int end_len, input int hide_pct,
                                 input int match_pct);
        int               seg;
        int               k;
        int               len;
        fill_t            fill;
        bit               hide;
        logic [2*EL_W-1:0] pair;
        for (seg = 0; seg <= end_seg; seg++)
        begin
            len  = (seg == end_seg) ? end_len : SEG_LEN;
            fill = ($urandom_range(0, 99) < match_pct) ? FILL_MATCHED
                                                        : fill_t'($urandom_range(0, 4));
            hide = $urandom_range(0, 99) < hide_pct;
            for (k = 0; k < len; k++)
            begin
                pair = make_pair(fill, k == 0, hide);
                send_pair(pair[2*EL_W-1:EL_W], pair[EL_W-1:0], seg == end_seg && k == len - 1);
            end
        end
    endtask

    task automatic send_short_templates(input int budget);
        int stop_at;
        stop_at = pairs_sent + budget;
        while (pairs_sent < stop_at)
            send_template(0, $urandom_range(1, 40), 20, 30);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_threshold(input logic signed [EL_W-1:0] value);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic send_directed();
        // visibility edge on either template
        send_pair(16'sd32767, 16'sd32767, 1'b1);
        send_pair(-16'sd3277, 16'sd0, 1'b1);
        send_pair(16'sd0, -16'sd3277, 1'b1);
        send_pair(-16'sd3276, -16'sd3276, 1'b1);
        send_pair(-16'sd32768, 16'sd32767, 1'b1);
        // dot saturation at the positive limit, then the most negative product
        send_pair(16'sd0, 16'sd0, 1'b0);
        send_pair(-16'sd32768, -16'sd32768, 1'b1);
        send_pair(16'sd0, 16'sd1, 1'b0);
        send_pair(16'sd32767, -16'sd32768, 1'b1);
        // floor of a small negative dot
        send_pair(16'sd1, -16'sd1, 1'b0);
        send_pair(-16'sd1, -16'sd1, 1'b1);
        send_pair(-16'sd1, 16'sd1, 1'b1);
        // dot at and just above the reset threshold
        send_pair(16'sd16385, 16'sd32767, 1'b1);
        send_pair(16'sd16386, 16'sd32767, 1'b1);
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        send_directed();
        // two full limb segments, the second closed by length and last together
        send_template(1, SEG_LEN, 15, 70);
        send_short_templates(SHORT_BUDGET);

        write_threshold(-16'sd32768);
        hold_off     = 1'b1;
        sender_idles = 1'b0;
        send_short_templates(PRESSURE_ITEMS);
        sender_idles = 1'b1;
        send_short_templates(SHORT_BUDGET);

        write_threshold(16'sd32767);
        sender_idles = 1'b0;
        send_short_templates(SHORT_BUDGET);

        write_threshold(16'sd0);
        sender_idles   = 1'b1;
        receiver_idles = 1'b0;
        send_short_templates(SHORT_BUDGET);

        write_threshold(16'($urandom_range(0, 65535)));
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        send_short_templates(SHORT_BUDGET);

        settle();
        $display("sent %0d element pairs in %0d templates, %0d scores checked",
                 pairs_sent, templates_sent, scores_seen);
        $display("limb threshold rewritten %0d times: both extremes, zero and a random value",
                 settings_used);
        if (fail_count == 0)
            $display("PASS segmented_feature_similarity");
        else
            $display("FAIL segmented_feature_similarity");
        $finish;
    end

endmodule
